/* sv/fmrt_pkg.sv */
// Shared types and constants for the flow meter rate and total block.
package fmrt_pkg;

    localparam int PERIOD_W = 32;
    localparam int RATE_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int VOL_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W = $clog2(PERIOD_W);

    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_INC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_UNIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

    // request kinds on s_tuser
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [PERIOD_W-1:0] RATE_NUM_RST  = 32'd1153153153;
    localparam logic [VOL_W-1:0]    VOL_INC_RST   = 16'd16;
    localparam logic [VOL_W-1:0]    VOL_UNIT_RST  = 16'd333;
    localparam logic [VOL_W-1:0]    TIMEOUT_RST   = 16'd1000;

    typedef struct packed {
        logic accept;    // item taken this cycle
        logic div_step;  // one divider iteration
        logic out_load;  // move result into the output register
    } fmrt_cmd_t;

    typedef struct packed {
        logic need_div;  // incoming item is a pulse with nonzero period
        logic div_last;  // divider is on its final iteration
    } fmrt_stat_t;

endpackage

/* sv/fmrt_ctrl.sv */
// Controller state machine: sequences accept, division and result hand-off.
module fmrt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fmrt_pkg::fmrt_stat_t stat,
    output fmrt_pkg::fmrt_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.need_div ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* sv/fmrt_dpath.sv */
// Datapath: config registers, volume accumulator, idle counter, divider, output register.
module fmrt_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [fmrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fmrt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              req_type,
    input  logic [fmrt_pkg::PERIOD_W-1:0]     period,
    input  fmrt_pkg::fmrt_cmd_t               cmd,
    output fmrt_pkg::fmrt_stat_t              stat,
    output logic [fmrt_pkg::RATE_W-1:0]       flow_rate,
    output logic [fmrt_pkg::TOTAL_W-1:0]      flow_total,
    output logic                              period_zero
);

    localparam int PW = fmrt_pkg::PERIOD_W;
    localparam int VW = fmrt_pkg::VOL_W;
    localparam int RW = fmrt_pkg::RATE_W;
    localparam int TW = fmrt_pkg::TOTAL_W;
    localparam int CW = fmrt_pkg::DIV_CNT_W;

    logic [PW-1:0] rate_num_reg;
    logic [VW-1:0] vol_inc_reg, vol_unit_reg, timeout_reg;

    logic [VW-1:0] accum_reg, accum_next;
    logic [TW-1:0] total_reg, total_next;
    logic [RW-1:0] rate_reg, rate_next;
    logic [VW-1:0] idle_reg, idle_next;
    logic          zero_reg, zero_next;

    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [PW-1:0] dvsr_reg, dvsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [RW-1:0] out_rate_reg;
    logic [TW-1:0] out_total_reg;
    logic          out_zero_reg;

    logic [VW:0]   sum_raw, sum_adj;
    logic          unit_hit;
    logic [VW-1:0] idle_inc;
    logic [PW:0]   trial;
    logic          q_bit;

    assign stat = '{need_div: (req_type == fmrt_pkg::REQ_PULSE) && (period != '0),
                    div_last: (cnt_reg == CW'(PW - 1))};

    // accumulator update for a pulse
    assign sum_raw  = {1'b0, accum_reg} + {1'b0, vol_inc_reg};
    assign unit_hit = (sum_raw >= {1'b0, vol_unit_reg});
    assign sum_adj  = unit_hit ? (sum_raw - {1'b0, vol_unit_reg}) : sum_raw;
    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + VW'(1);

    // restoring divider: shift numerator in from the top of the quotient register
    assign trial = {rem_reg, quo_reg[PW-1]} - {1'b0, dvsr_reg};
    assign q_bit = !trial[PW];

    always_comb begin
        accum_next = accum_reg;
        total_next = total_reg;
        rate_next  = rate_reg;
        idle_next  = idle_reg;
        zero_next  = zero_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvsr_next  = dvsr_reg;
        cnt_next   = cnt_reg;
        if (cmd.accept) begin
            if (req_type == fmrt_pkg::REQ_PULSE) begin
                accum_next = sum_adj[VW] ? '1 : sum_adj[VW-1:0];
                total_next = unit_hit ? total_reg + TW'(1) : total_reg;
                idle_next  = '0;
                zero_next  = (period == '0);
                if (period == '0) begin
                    rate_next = fmrt_pkg::RATE_MAX;
                end
                rem_next  = '0;
                quo_next  = rate_num_reg;
                dvsr_next = period;
                cnt_next  = '0;
            end else begin
                idle_next = idle_inc;
                zero_next = 1'b0;
                if (idle_inc >= timeout_reg) begin
                    rate_next = '0;
                end
            end
        end
        if (cmd.div_step) begin
            rem_next = q_bit ? trial[PW-1:0] : {rem_reg[PW-2:0], quo_reg[PW-1]};
            quo_next = {quo_reg[PW-2:0], q_bit};
            cnt_next = cnt_reg + CW'(1);
            if (stat.div_last) begin
                rate_next = (quo_next[PW-1:RW] != '0) ? fmrt_pkg::RATE_MAX
                                                      : quo_next[RW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_num_reg <= fmrt_pkg::RATE_NUM_RST;
            vol_inc_reg  <= fmrt_pkg::VOL_INC_RST;
            vol_unit_reg <= fmrt_pkg::VOL_UNIT_RST;
            timeout_reg  <= fmrt_pkg::TIMEOUT_RST;
            accum_reg    <= '0;
            total_reg    <= '0;
            rate_reg     <= '0;
            idle_reg     <= '0;
            zero_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    fmrt_pkg::CFG_RATE_NUM: rate_num_reg <= cfg_data;
                    fmrt_pkg::CFG_VOL_INC:  vol_inc_reg  <= cfg_data[VW-1:0];
                    fmrt_pkg::CFG_VOL_UNIT: vol_unit_reg <= cfg_data[VW-1:0];
                    fmrt_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data[VW-1:0];
                    default: ;
                endcase
            end
            accum_reg <= accum_next;
            total_reg <= total_next;
            rate_reg  <= rate_next;
            idle_reg  <= idle_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
        cnt_reg  <= cnt_next;
        if (cmd.out_load) begin
            out_rate_reg  <= rate_reg;
            out_total_reg <= total_reg;
            out_zero_reg  <= zero_reg;
        end
    end

    assign flow_rate   = out_rate_reg;
    assign flow_total  = out_total_reg;
    assign period_zero = out_zero_reg;

endmodule

/* sv/flow_meter_rate_and_total.sv */
// Top level of the flow meter rate and total block.
// A pulse item adds the volume increment to the accumulator, counts a whole unit when the
// accumulator reaches the unit size, and sets the rate to rate_numerator / period,
// saturated at 65535 (65535 and period_zero set for a zero period). A tick item advances
// the idle counter and clears the rate once timeout_ticks is reached. Each item gives one
// result. A pulse with a nonzero period is accepted, runs 32 iterations of the restoring
// divider, then loads the output register once it is free; ticks and zero-period pulses
// skip the divider. The output register lets the next item be accepted while a result
// waits on m_tready. Configuration writes are always ready; write them only while the
// block is idle.
module flow_meter_rate_and_total (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fmrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmrt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // period[31:0]
    input  logic                            s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // flow_rate[15:0], flow_total[47:16]
    output logic                            m_tuser    // period_zero
);

    fmrt_pkg::fmrt_cmd_t  cmd;
    fmrt_pkg::fmrt_stat_t stat;
    logic [fmrt_pkg::RATE_W-1:0]  flow_rate;
    logic [fmrt_pkg::TOTAL_W-1:0] flow_total;

    assign cfg_ready = 1'b1;

    fmrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmrt_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (s_tuser),
        .period      (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .flow_rate   (flow_rate),
        .flow_total  (flow_total),
        .period_zero (m_tuser)
    );

    assign m_tdata = {flow_total, flow_rate};

    // the divider only runs while the input side is closed
    a_div_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_tready)
        else $error("divider stepping while input is ready");

    // ticks and zero-period pulses skip the divider
    a_no_div_without_need: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !stat.need_div) |=> !cmd.div_step)
        else $error("divider started for an item that needs no division");

    // a zero-period result always reports the saturated rate
    a_zero_period_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[15:0] == fmrt_pkg::RATE_MAX))
        else $error("zero period result without saturated rate");

endmodule
